### rtl/wrd_pkg.sv
// ----------------------------------------------------------------------------
// wrd_pkg
// Shared types, codes and default sizes for the work range dispatcher.
// ----------------------------------------------------------------------------
package wrd_pkg;

   // default sizes for the top level parameters
   localparam int DEF_NODES       = 16;
   localparam int DEF_SPARE_DEPTH = 16;
   localparam int DEF_INDEX_BITS  = 48;

   // most results one tick sweep may produce
   localparam int MAX_RESULTS = 16;

   // fixed field widths
   localparam int MODE_W    = 2;
   localparam int NODE_W    = 4;
   localparam int IDX_W     = 48;
   localparam int STATUS_W  = 4;
   localparam int BLOCK_W   = 32;
   localparam int TIMEOUT_W = 16;
   localparam int AGE_W     = 16;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BLOCK_W-1:0]   BLOCK_SIZE_RST = 32'd1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 16'd10;

   typedef enum logic [MODE_W-1:0] {
      MODE_REQUEST = 2'd0,
      MODE_FOUND   = 2'd1,
      MODE_LEAVE   = 2'd2,
      MODE_TICK    = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ASSIGNED     = 4'd0,
      ST_STOP         = 4'd1,
      ST_FOUND_OK     = 4'd2,
      ST_FOUND_DUP    = 4'd3,
      ST_RECLAIMED    = 4'd4,
      ST_LEFT_EMPTY   = 4'd5,
      ST_TIMEOUT_RECL = 4'd6,
      ST_TIMEOUT_NONE = 4'd7,
      ST_DROPPED      = 4'd8,
      ST_EXHAUSTED    = 4'd9
   } status_type;

   // register map: index = byte address / 4
   typedef enum logic {
      REG_BLOCK_SIZE = 1'b0,
      REG_TIMEOUT    = 1'b1
   } reg_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]   block_size;
      logic [TIMEOUT_W-1:0] timeout_ticks;
   } cfg_type;

endpackage

### rtl/wrd_req_if.sv
// ----------------------------------------------------------------------------
// wrd_req_if
// Event channel into the dispatcher: valid/ready plus one event beat.
// ----------------------------------------------------------------------------
interface wrd_req_if import wrd_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [NODE_W-1:0] node_id;
   logic [IDX_W-1:0]  found_index;

   modport source (output valid, output mode, output node_id, output found_index,
                   input ready);
   modport sink   (input valid, input mode, input node_id, input found_index,
                   output ready);

endinterface

### rtl/wrd_rsp_if.sv
// ----------------------------------------------------------------------------
// wrd_rsp_if
// Result channel out of the dispatcher: valid/ready plus one result beat.
// ----------------------------------------------------------------------------
interface wrd_rsp_if import wrd_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NODE_W-1:0]   node_out;
   logic [IDX_W-1:0]    range_first;
   logic [IDX_W-1:0]    range_last;
   logic [IDX_W-1:0]    solution_index;
   logic                last;

   modport source (output valid, output status, output node_out, output range_first,
                   output range_last, output solution_index, output last,
                   input ready);
   modport sink   (input valid, input status, input node_out, input range_first,
                   input range_last, input solution_index, input last,
                   output ready);

endinterface

### rtl/wrd_ram.sv
// ----------------------------------------------------------------------------
// wrd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module wrd_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wrd_csr.sv
// ----------------------------------------------------------------------------
// wrd_csr
// APB register block: block size and timeout, with read back.
// ----------------------------------------------------------------------------
module wrd_csr import wrd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [BLOCK_W-1:0]   block_size_ff,  block_size_in;
   logic [TIMEOUT_W-1:0] timeout_ff,     timeout_in;
   reg_type              reg_sel;
   logic                 wr_beat;

   assign pready  = 1'b1;
   assign reg_sel = reg_type'(paddr[CSR_ADDR_W-1]);
   assign wr_beat = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      block_size_in = block_size_ff;
      timeout_in    = timeout_ff;
      if (wr_beat) begin
         unique case (reg_sel)
            REG_BLOCK_SIZE: begin
               block_size_in = pwdata[BLOCK_W-1:0];
            end
            REG_TIMEOUT: begin
               timeout_in = pwdata[TIMEOUT_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_SIZE_RST;
         timeout_ff    <= TIMEOUT_RST;
      end else begin
         block_size_ff <= block_size_in;
         timeout_ff    <= timeout_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_sel)
         REG_BLOCK_SIZE: begin
            prdata = CSR_DATA_W'(block_size_ff);
         end
         REG_TIMEOUT: begin
            prdata = CSR_DATA_W'(timeout_ff);
         end
      endcase
   end

   assign cfg.block_size    = block_size_ff;
   assign cfg.timeout_ticks = timeout_ff;

endmodule

### rtl/work_range_dispatcher.sv
// ----------------------------------------------------------------------------
// work_range_dispatcher
// Hands out index ranges to worker nodes, reclaims ranges of nodes that
// leave or time out through a spare stack, and latches the first find.
// ----------------------------------------------------------------------------
//
//   port      dir   kind       beat
//   req_bus   in    valid/rdy  mode, node_id, found_index
//   rsp_bus   out   valid/rdy  status, node_out, range_first/last, solution, last
//   p*        in    APB        block_size @0x0, timeout_ticks @0x4
//
// Request and found beats pass EXEC and FINISH from accept to result; a pop
// from the spare stack or a leave adds POP_WAIT or LEAVE_WAIT for the RAM
// read. A tick sweeps the node slots one at a time through the age and held
// range RAMs: TICK_RD for an idle slot, TICK_RD and TICK_EV for a tracked one.
// Reset is synchronous; per node flags live in flip-flops, so no RAM clear.
// A result waits in the output register; the sequencer stalls only when it
// has a result to hand over while that register is still full.
// ----------------------------------------------------------------------------
module work_range_dispatcher import wrd_pkg::*; #(
   parameter int NODES       = DEF_NODES,
   parameter int SPARE_DEPTH = DEF_SPARE_DEPTH,
   parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   wrd_req_if.sink               req_bus,
   wrd_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NW = $clog2(NODES);
   localparam int SW = $clog2(SPARE_DEPTH);
   localparam int CW = $clog2(SPARE_DEPTH + 1);
   localparam int KW = $clog2(MAX_RESULTS + 1);
   localparam int AW = ((INDEX_BITS > BLOCK_W) ? INDEX_BITS : BLOCK_W) + 1;
   localparam int RW = 2 * INDEX_BITS;
   localparam logic [INDEX_BITS-1:0] IDX_MAX   = '1;
   localparam logic [NW-1:0]         LAST_SLOT = NW'(NODES - 1);

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_EXEC       = 7'b0000010,
      S_POP_WAIT   = 7'b0000100,
      S_LEAVE_WAIT = 7'b0001000,
      S_TICK_RD    = 7'b0010000,
      S_TICK_EV    = 7'b0100000,
      S_FINISH     = 7'b1000000
   } state_type;

   cfg_type cfg;

   // sequencer and item registers
   state_type              state_ff,       state_in;
   mode_type               mode_ff,        mode_in;
   logic [NODE_W-1:0]      node_id_ff,     node_id_in;
   logic [IDX_W-1:0]       fidx_ff,        fidx_in;
   logic [NW-1:0]          slot_ff,        slot_in;
   logic [KW-1:0]          k_ff,           k_in;

   // dispatcher state
   logic                   found_ff,       found_in;
   logic [INDEX_BITS-1:0]  found_value_ff, found_value_in;
   logic [INDEX_BITS-1:0]  next_start_ff,  next_start_in;
   logic [CW-1:0]          spare_count_ff, spare_count_in;
   logic [NODES-1:0]       tracked_ff,     tracked_in;
   logic [NODES-1:0]       holds_ff,       holds_in;

   // pending result; the final one of an item is sent with last once it is done
   logic                   pend_valid_ff,  pend_valid_in;
   status_type             pend_status_ff, pend_status_in;
   logic [NODE_W-1:0]      pend_node_ff,   pend_node_in;
   logic [INDEX_BITS-1:0]  pend_first_ff,  pend_first_in;
   logic [INDEX_BITS-1:0]  pend_last_ff,   pend_last_in;

   // output register
   logic                   out_valid_ff,   out_valid_in;
   status_type             out_status_ff;
   logic [NODE_W-1:0]      out_node_ff;
   logic [IDX_W-1:0]       out_first_ff;
   logic [IDX_W-1:0]       out_last_ff;
   logic [IDX_W-1:0]       out_sol_ff;
   logic                   out_end_ff;
   logic                   out_load;
   logic                   out_load_end;
   logic                   out_free;

   // RAM ports
   logic                   held_wr_en,  held_rd_en;
   logic [NW-1:0]          held_wr_addr, held_rd_addr;
   logic [RW-1:0]          held_wr_data, held_rd_data;
   logic                   age_wr_en,   age_rd_en;
   logic [NW-1:0]          age_wr_addr,  age_rd_addr;
   logic [AGE_W-1:0]       age_wr_data,  age_rd_data;
   logic                   spare_wr_en, spare_rd_en;
   logic [SW-1:0]          spare_wr_addr, spare_rd_addr;
   logic [RW-1:0]          spare_wr_data, spare_rd_data;

   // datapath helpers
   logic [NW-1:0]          node_idx;
   logic                   node_ok;
   logic [BLOCK_W-1:0]     bs_eff;
   logic [BLOCK_W-1:0]     bs_m1;
   logic [AW-1:0]          fresh_end;
   logic [INDEX_BITS-1:0]  fresh_last;
   logic                   exhausted;
   logic [CW-1:0]          spare_top;
   logic [NW-1:0]          rel_node;
   logic                   rel_holds;
   logic                   spare_room;
   logic                   rel_push;
   logic [INDEX_BITS-1:0]  rd_first;
   logic [INDEX_BITS-1:0]  rd_last;
   logic [AGE_W-1:0]       age_next;
   logic                   expire;

   wrd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // held range per node: {first, last}
   wrd_ram #(.WIDTH(RW), .DEPTH(NODES)) u_held_ram (
      .clock   (clock),
      .wr_en   (held_wr_en),
      .wr_addr (held_wr_addr),
      .wr_data (held_wr_data),
      .rd_en   (held_rd_en),
      .rd_addr (held_rd_addr),
      .rd_data (held_rd_data)
   );

   // age per node, meaningful only while tracked
   wrd_ram #(.WIDTH(AGE_W), .DEPTH(NODES)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_wr_en),
      .wr_addr (age_wr_addr),
      .wr_data (age_wr_data),
      .rd_en   (age_rd_en),
      .rd_addr (age_rd_addr),
      .rd_data (age_rd_data)
   );

   // spare stack of reclaimed ranges
   wrd_ram #(.WIDTH(RW), .DEPTH(SPARE_DEPTH)) u_spare_ram (
      .clock   (clock),
      .wr_en   (spare_wr_en),
      .wr_addr (spare_wr_addr),
      .wr_data (spare_wr_data),
      .rd_en   (spare_rd_en),
      .rd_addr (spare_rd_addr),
      .rd_data (spare_rd_data)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   // fresh block: next + bs in a wider sum, so the overflow test is one compare
   always_comb begin
      node_idx   = NW'(node_id_ff);
      node_ok    = (32'(node_id_ff) < 32'(NODES));
      bs_eff     = (cfg.block_size == '0) ? BLOCK_W'(1) : cfg.block_size;
      bs_m1      = (cfg.block_size == '0) ? '0 : cfg.block_size - BLOCK_W'(1);
      fresh_end  = AW'(next_start_ff) + AW'(bs_eff);
      fresh_last = next_start_ff + INDEX_BITS'(bs_m1);
      exhausted  = fresh_end > AW'(IDX_MAX);
      spare_top  = spare_count_ff - CW'(1);
   end

   // release of one node, shared by leave and tick timeout
   always_comb begin
      rel_node   = (state_ff == S_TICK_EV) ? slot_ff : node_idx;
      rel_holds  = holds_ff[rel_node];
      spare_room = spare_count_ff < CW'(SPARE_DEPTH);
      rel_push   = rel_holds && spare_room;
      rd_first   = held_rd_data[RW-1:INDEX_BITS];
      rd_last    = held_rd_data[INDEX_BITS-1:0];
      age_next   = (age_rd_data == '1) ? age_rd_data : age_rd_data + AGE_W'(1);
      expire     = (age_next > cfg.timeout_ticks) && (k_ff < KW'(MAX_RESULTS));
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      node_id_in     = node_id_ff;
      fidx_in        = fidx_ff;
      slot_in        = slot_ff;
      k_in           = k_ff;
      found_in       = found_ff;
      found_value_in = found_value_ff;
      next_start_in  = next_start_ff;
      spare_count_in = spare_count_ff;
      tracked_in     = tracked_ff;
      holds_in       = holds_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_node_in   = pend_node_ff;
      pend_first_in  = pend_first_ff;
      pend_last_in   = pend_last_ff;
      out_load       = 1'b0;
      out_load_end   = 1'b0;

      held_wr_en     = 1'b0;
      held_wr_addr   = node_idx;
      held_wr_data   = {next_start_ff, fresh_last};
      held_rd_en     = 1'b0;
      held_rd_addr   = node_idx;
      age_wr_en      = 1'b0;
      age_wr_addr    = node_idx;
      age_wr_data    = '0;
      age_rd_en      = 1'b0;
      age_rd_addr    = slot_ff;
      spare_wr_en    = 1'b0;
      spare_wr_addr  = spare_count_ff[SW-1:0];
      spare_wr_data  = held_rd_data;
      spare_rd_en    = 1'b0;
      spare_rd_addr  = spare_top[SW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               mode_in    = mode_type'(req_bus.mode);
               node_id_in = req_bus.node_id;
               fidx_in    = req_bus.found_index;
               state_in   = S_EXEC;
            end
         end

         S_EXEC: begin
            if (mode_ff == MODE_TICK) begin
               slot_in  = '0;
               k_in     = '0;
               state_in = S_TICK_RD;
            end else if (!node_ok) begin
               state_in = S_IDLE;
            end else begin
               pend_node_in  = node_id_ff;
               pend_first_in = '0;
               pend_last_in  = '0;
               pend_valid_in = 1'b1;
               state_in      = S_FINISH;
               unique case (mode_ff)
                  MODE_REQUEST: begin
                     tracked_in[node_idx] = 1'b1;
                     age_wr_en = 1'b1;
                     if (found_ff) begin
                        pend_status_in = ST_STOP;
                     end else if (spare_count_ff != '0) begin
                        // pop the top range, finish once the RAM returns it
                        spare_rd_en    = 1'b1;
                        spare_count_in = spare_top;
                        pend_valid_in  = 1'b0;
                        state_in       = S_POP_WAIT;
                     end else if (exhausted) begin
                        pend_status_in = ST_EXHAUSTED;
                     end else begin
                        held_wr_en         = 1'b1;
                        holds_in[node_idx] = 1'b1;
                        next_start_in      = fresh_end[INDEX_BITS-1:0];
                        pend_status_in     = ST_ASSIGNED;
                        pend_first_in      = next_start_ff;
                        pend_last_in       = fresh_last;
                     end
                  end
                  MODE_FOUND: begin
                     tracked_in[node_idx] = 1'b1;
                     age_wr_en = 1'b1;
                     if (!found_ff) begin
                        found_in       = 1'b1;
                        found_value_in = INDEX_BITS'(fidx_ff);
                        pend_status_in = ST_FOUND_OK;
                     end else begin
                        pend_status_in = ST_FOUND_DUP;
                     end
                  end
                  default: begin
                     // node leaves: fetch its range first
                     held_rd_en    = 1'b1;
                     pend_valid_in = 1'b0;
                     state_in      = S_LEAVE_WAIT;
                  end
               endcase
            end
         end

         S_POP_WAIT: begin
            held_wr_en         = 1'b1;
            held_wr_data       = spare_rd_data;
            holds_in[node_idx] = 1'b1;
            pend_valid_in      = 1'b1;
            pend_status_in     = ST_ASSIGNED;
            pend_first_in      = spare_rd_data[RW-1:INDEX_BITS];
            pend_last_in       = spare_rd_data[INDEX_BITS-1:0];
            state_in           = S_FINISH;
         end

         S_LEAVE_WAIT: begin
            tracked_in[node_idx] = 1'b0;
            holds_in[node_idx]   = 1'b0;
            pend_valid_in        = 1'b1;
            pend_first_in        = rd_first;
            pend_last_in         = rd_last;
            if (!rel_holds) begin
               pend_status_in = ST_LEFT_EMPTY;
               pend_first_in  = '0;
               pend_last_in   = '0;
            end else if (rel_push) begin
               spare_wr_en    = 1'b1;
               spare_count_in = spare_count_ff + CW'(1);
               pend_status_in = ST_RECLAIMED;
            end else begin
               pend_status_in = ST_DROPPED;
            end
            state_in = S_FINISH;
         end

         S_TICK_RD: begin
            if (tracked_ff[slot_ff]) begin
               age_rd_en    = 1'b1;
               held_rd_en   = 1'b1;
               held_rd_addr = slot_ff;
               state_in     = S_TICK_EV;
            end else if (slot_ff == LAST_SLOT) begin
               state_in = S_FINISH;
            end else begin
               slot_in = slot_ff + NW'(1);
            end
         end

         S_TICK_EV: begin
            // a new result needs the older pending one moved out first
            if (!(expire && pend_valid_ff && !out_free)) begin
               if (expire) begin
                  tracked_in[slot_ff] = 1'b0;
                  holds_in[slot_ff]   = 1'b0;
                  out_load            = pend_valid_ff;
                  pend_valid_in       = 1'b1;
                  pend_node_in        = NODE_W'(slot_ff);
                  pend_first_in       = rd_first;
                  pend_last_in        = rd_last;
                  k_in                = k_ff + KW'(1);
                  if (!rel_holds) begin
                     pend_status_in = ST_TIMEOUT_NONE;
                     pend_first_in  = '0;
                     pend_last_in   = '0;
                  end else if (rel_push) begin
                     spare_wr_en    = 1'b1;
                     spare_count_in = spare_count_ff + CW'(1);
                     pend_status_in = ST_TIMEOUT_RECL;
                  end else begin
                     pend_status_in = ST_DROPPED;
                  end
               end else begin
                  age_wr_en   = 1'b1;
                  age_wr_addr = slot_ff;
                  age_wr_data = age_next;
               end
               if (slot_ff == LAST_SLOT) begin
                  state_in = S_FINISH;
               end else begin
                  slot_in  = slot_ff + NW'(1);
                  state_in = S_TICK_RD;
               end
            end
         end

         S_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_load_end  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      out_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         found_ff       <= 1'b0;
         found_value_ff <= '0;
         next_start_ff  <= '0;
         spare_count_ff <= '0;
         tracked_ff     <= '0;
         holds_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         found_ff       <= found_in;
         found_value_ff <= found_value_in;
         next_start_ff  <= next_start_in;
         spare_count_ff <= spare_count_in;
         tracked_ff     <= tracked_in;
         holds_ff       <= holds_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      node_id_ff     <= node_id_in;
      fidx_ff        <= fidx_in;
      slot_ff        <= slot_in;
      k_ff           <= k_in;
      pend_status_ff <= pend_status_in;
      pend_node_ff   <= pend_node_in;
      pend_first_ff  <= pend_first_in;
      pend_last_ff   <= pend_last_in;
      if (out_load) begin
         out_status_ff <= pend_status_ff;
         out_node_ff   <= pend_node_ff;
         out_first_ff  <= IDX_W'(pend_first_ff);
         out_last_ff   <= IDX_W'(pend_last_ff);
         out_sol_ff    <= IDX_W'(found_value_ff);
         out_end_ff    <= out_load_end;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.status         = out_status_ff;
   assign rsp_bus.node_out       = out_node_ff;
   assign rsp_bus.range_first    = out_first_ff;
   assign rsp_bus.range_last     = out_last_ff;
   assign rsp_bus.solution_index = out_sol_ff;
   assign rsp_bus.last           = out_end_ff;

endmodule
